FILE: src/sspb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspb_pkg
// shared types, widths, register indexes and color helpers of the blitter
// ----------------------------------------------------------------------------
package sspb_pkg;

   localparam int DIM_W       = 13;
   localparam int ZOOM_W      = 4;
   localparam int MUL_W       = DIM_W + ZOOM_W;
   localparam int POS_W       = MUL_W + 2;
   localparam int COORD_W     = 13;
   localparam int X_W         = 9;
   localparam int Y_W         = 8;
   localparam int COLOR_W     = 16;
   localparam int SRC_W       = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [CSR_IDX_W-1:0] REG_DEST_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VISIBLE_ROWS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BLIT_MODE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FLAT_COLOR   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_COLOR    = 3'd7;

   typedef struct packed {
      logic [15:0]        dest_x;
      logic [15:0]        dest_y;
      logic [10:0]        image_width;
      logic [10:0]        image_height;
      logic [10:0]        visible_rows;
      logic [14:0]        blit_mode;
      logic [COLOR_W-1:0] flat_color;
      logic [COLOR_W-1:0] key_color;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] y1;
      logic [COLOR_W-1:0] color;
   } block_type;

   function automatic logic [4:0] shade_channel(input logic [4:0] c, input logic [7:0] s);
      logic [12:0] p;
      p = 13'(c) * 13'(s);
      shade_channel = (p[12:3] > 10'd31) ? 5'd31 : p[7:3];
   endfunction

   function automatic logic [COLOR_W-1:0] apply_shade(input logic [COLOR_W-1:0] color,
                                                      input logic [7:0] s);
      apply_shade = {1'b0, shade_channel(color[14:10], s), shade_channel(color[9:5], s),
                     shade_channel(color[4:0], s)};
   endfunction

endpackage
`default_nettype wire

FILE: src/sspb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspb_front
// takes source pixels, keys, recolors, maps and clips them into screen blocks
// ----------------------------------------------------------------------------
module sspb_front import sspb_pkg::*; #(
   parameter int SCREEN_WIDTH   = 320,
   parameter int SCREEN_HEIGHT  = 240,
   parameter int MAX_ZOOM       = 8,
   parameter int MAX_IMAGE_SIDE = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [COLOR_W-1:0] pixel_color,
   input  wire logic [SRC_W-1:0]   src_col,
   input  wire logic [SRC_W-1:0]   src_row,
   input  wire cfg_type            cfg,
   output logic                    push,
   output block_type               push_block,
   output logic [1:0]              inflight
);

   localparam logic [DIM_W-1:0]        SIDE  = DIM_W'(MAX_IMAGE_SIDE);
   localparam logic [ZOOM_W-1:0]       ZMAX  = ZOOM_W'(MAX_ZOOM);
   localparam logic signed [POS_W-1:0] SW_POS = POS_W'(SCREEN_WIDTH);
   localparam logic signed [POS_W-1:0] SH_POS = POS_W'(SCREEN_HEIGHT);

   // input word stage
   logic               s0_valid_ff, s0_valid_in;
   logic [COLOR_W-1:0] s0_color_ff;
   logic [SRC_W-1:0]   s0_col_ff, s0_row_ff;

   // classify stage
   logic               s1_valid_ff, s1_valid_in;
   logic [MUL_W-1:0]   s1_mul_x_ff, s1_mul_x_in, s1_mul_y_ff, s1_mul_y_in;
   logic [ZOOM_W-1:0]  s1_zoom_ff, s1_zoom_in;
   logic [COLOR_W-1:0] s1_color_ff, s1_color_in;

   logic [DIM_W-1:0]   w, h, rows, vis, col_e, row_e, sx, sy;
   logic [ZOOM_W-1:0]  zoom_raw;
   logic [7:0]         shade;
   logic               keep;

   logic signed [POS_W-1:0] bx, by, ex, ey, x0, x1, y0, y1;

   assign s0_valid_in = take;

   always_comb begin
      w        = (DIM_W'(cfg.image_width) > SIDE) ? SIDE : DIM_W'(cfg.image_width);
      h        = (DIM_W'(cfg.image_height) > SIDE) ? SIDE : DIM_W'(cfg.image_height);
      vis      = DIM_W'(cfg.visible_rows);
      rows     = (vis != '0 && vis < h) ? vis : h;
      col_e    = DIM_W'(s0_col_ff);
      row_e    = DIM_W'(s0_row_ff);
      sx       = cfg.blit_mode[0] ? (w - DIM_W'(1) - col_e) : col_e;
      sy       = cfg.blit_mode[1] ? (h - DIM_W'(1) - row_e) : row_e;
      keep     = (col_e < w) && (row_e < h) && (s0_color_ff != cfg.key_color) && (sy < rows);
      zoom_raw = cfg.blit_mode[6:3];
      shade    = cfg.blit_mode[14:7];
      if (zoom_raw < ZOOM_W'(2)) begin
         s1_zoom_in = ZOOM_W'(1);
      end else if (zoom_raw > ZMAX) begin
         s1_zoom_in = ZMAX;
      end else begin
         s1_zoom_in = zoom_raw;
      end
      if (cfg.blit_mode[2]) begin
         s1_color_in = cfg.flat_color;
      end else if (shade != 8'd0 && shade != 8'd8) begin
         s1_color_in = apply_shade(s0_color_ff, shade);
      end else begin
         s1_color_in = s0_color_ff;
      end
      s1_valid_in = s0_valid_ff && keep;
      s1_mul_x_in = MUL_W'(sx) * MUL_W'(s1_zoom_in);
      s1_mul_y_in = MUL_W'(sy) * MUL_W'(s1_zoom_in);
   end

   // block placement and clipping
   always_comb begin
      bx = $signed({{(POS_W-16){cfg.dest_x[15]}}, cfg.dest_x}) + $signed(POS_W'(s1_mul_x_ff));
      by = $signed({{(POS_W-16){cfg.dest_y[15]}}, cfg.dest_y}) + $signed(POS_W'(s1_mul_y_ff));
      ex = bx + $signed(POS_W'(s1_zoom_ff));
      ey = by + $signed(POS_W'(s1_zoom_ff));
      x0 = bx[POS_W-1] ? '0 : bx;
      y0 = by[POS_W-1] ? '0 : by;
      x1 = (ex > SW_POS) ? SW_POS : ex;
      y1 = (ey > SH_POS) ? SH_POS : ey;
      push = s1_valid_ff && (x0 < x1) && (y0 < y1);
      push_block.x0    = COORD_W'(x0);
      push_block.x1    = COORD_W'(x1);
      push_block.y0    = COORD_W'(y0);
      push_block.y1    = COORD_W'(y1);
      push_block.color = s1_color_ff;
   end

   assign inflight = {1'b0, s0_valid_ff} + {1'b0, s1_valid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (take) begin
         s0_color_ff <= pixel_color;
         s0_col_ff   <= src_col;
         s0_row_ff   <= src_row;
      end
      s1_mul_x_ff <= s1_mul_x_in;
      s1_mul_y_ff <= s1_mul_y_in;
      s1_zoom_ff  <= s1_zoom_in;
      s1_color_ff <= s1_color_in;
   end

endmodule
`default_nettype wire

FILE: src/sspb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspb_queue
// short block queue between the classify front and the draw engine
// ----------------------------------------------------------------------------
module sspb_queue import sspb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire block_type   push_block,
   input  wire logic        pop,
   output block_type        head,
   output logic             empty,
   output logic [QCNT_W-1:0] count
);

   block_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_block;
      end
   end

endmodule
`default_nettype wire

FILE: src/sspb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspb_back
// draw engine: walks each queued block row by row, one screen write a cycle
// ----------------------------------------------------------------------------
module sspb_back import sspb_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire block_type     head,
   input  wire logic          empty,
   output logic               pop,
   output logic               rsp_valid,
   output logic [X_W-1:0]     rsp_screen_x,
   output logic [Y_W-1:0]     rsp_screen_y,
   output logic [COLOR_W-1:0] rsp_write_color,
   output logic               rsp_is_last
);

   logic               active_ff, active_in;
   block_type          blk_ff, blk_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, nx, ny;
   logic               x_end, y_end, last_now;

   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [X_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [Y_W-1:0]     rsp_y_ff, rsp_y_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   always_comb begin
      nx       = cur_x_ff + COORD_W'(1);
      ny       = cur_y_ff + COORD_W'(1);
      x_end    = (nx == blk_ff.x1);
      y_end    = (ny == blk_ff.y1);
      last_now = active_ff && x_end && y_end;
      pop      = (!active_ff || last_now) && !empty;

      rsp_valid_in = active_ff;
      rsp_x_in     = X_W'(cur_x_ff);
      rsp_y_in     = Y_W'(cur_y_ff);
      rsp_color_in = blk_ff.color;
      rsp_last_in  = x_end && y_end;

      active_in = active_ff;
      blk_in    = blk_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      if (pop) begin
         active_in = 1'b1;
         blk_in    = head;
         cur_x_in  = head.x0;
         cur_y_in  = head.y0;
      end else if (last_now) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         if (x_end) begin
            cur_x_in = blk_ff.x0;
            cur_y_in = ny;
         end else begin
            cur_x_in = nx;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_screen_x    = rsp_x_ff;
   assign rsp_screen_y    = rsp_y_ff;
   assign rsp_write_color = rsp_color_ff;
   assign rsp_is_last     = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_ff       <= blk_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule
`default_nettype wire

FILE: src/scaled_sprite_blitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_sprite_blitter
// chroma-keyed sprite blitter with recolor, mirror, flip, zoom and clipping
// ----------------------------------------------------------------------------
// A pixel taken on start passes the input word and classify stage registers
// into the block queue; with the draw engine idle it is then loaded into the
// block register and its first screen word leaves through the result
// registers. A pixel that is keyed out, past the visible rows or wholly off
// screen costs no draw time. The draw engine writes one screen word per
// cycle, so a pixel occupies it for its visible writes: zoom squared at most,
// 64 at zoom 8, four at zoom 2, with no gap between blocks. busy is high
// while the queued blocks plus the pixels in the two front stages number
// four, the queue depth, so a taken pixel always finds room. Results come out
// on a one-cycle rsp_valid strobe and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module scaled_sprite_blitter import sspb_pkg::*; #(
   parameter int SCREEN_WIDTH   = 320,
   parameter int SCREEN_HEIGHT  = 240,
   parameter int MAX_ZOOM       = 8,
   parameter int MAX_IMAGE_SIDE = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [COLOR_W-1:0]    req_pixel_color,
   input  wire logic [SRC_W-1:0]      req_src_col,
   input  wire logic [SRC_W-1:0]      req_src_row,
   output logic                       rsp_valid,
   output logic [X_W-1:0]             rsp_screen_x,
   output logic [Y_W-1:0]             rsp_screen_y,
   output logic [COLOR_W-1:0]         rsp_write_color,
   output logic                       rsp_is_last,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type           cfg_ff, cfg_in;
   logic              take, push, pop, empty;
   block_type         push_block, head;
   logic [1:0]        inflight;
   logic [QCNT_W-1:0] count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_DEST_X:       cfg_in.dest_x       = csr_data;
            REG_DEST_Y:       cfg_in.dest_y       = csr_data;
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_data[10:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_data[10:0];
            REG_VISIBLE_ROWS: cfg_in.visible_rows = csr_data[10:0];
            REG_BLIT_MODE:    cfg_in.blit_mode    = csr_data[14:0];
            REG_FLAT_COLOR:   cfg_in.flat_color   = csr_data;
            REG_KEY_COLOR:    cfg_in.key_color    = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x       <= '0;
         cfg_ff.dest_y       <= '0;
         cfg_ff.image_width  <= 11'd1;
         cfg_ff.image_height <= 11'd1;
         cfg_ff.visible_rows <= '0;
         cfg_ff.blit_mode    <= 15'd8;
         cfg_ff.flat_color   <= '0;
         cfg_ff.key_color    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy = ((count + QCNT_W'(inflight)) >= QCNT_W'(QUEUE_DEPTH));
   assign take = start && !busy;

   sspb_front #(
      .SCREEN_WIDTH   (SCREEN_WIDTH),
      .SCREEN_HEIGHT  (SCREEN_HEIGHT),
      .MAX_ZOOM       (MAX_ZOOM),
      .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .pixel_color (req_pixel_color),
      .src_col     (req_src_col),
      .src_row     (req_src_row),
      .cfg         (cfg_ff),
      .push        (push),
      .push_block  (push_block),
      .inflight    (inflight)
   );

   sspb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_block (push_block),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .count      (count)
   );

   sspb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_write_color (rsp_write_color),
      .rsp_is_last     (rsp_is_last)
   );

endmodule
`default_nettype wire
